// File: sv/lip_pkg.sv
// Package for the line intersection parameter block.
// Holds the widths, limits and shared types; no dependencies.
package lip_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 48;

    // A coordinate difference needs one extra bit and a product twice that.
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    // The magnitude of a cross-product difference stays below 2^(2*COORD_BITS+1).
    localparam int MAG_W   = 2 * COORD_BITS + 1;
    localparam int CROSS_W = MAG_W + 1;
    localparam int DVD_W   = MAG_W + FRAC_BITS;
    localparam int SAT_W   = (DVD_W > OUT_BITS) ? DVD_W : OUT_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic        [MAG_W-1:0]      t_mag;
    typedef logic        [DVD_W-1:0]      t_dq;
    typedef logic        [OUT_BITS-1:0]   t_out;
    typedef logic        [SAT_W-1:0]      t_wide;

    localparam t_out POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam t_out NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } t_ctl;

    typedef struct packed {
        t_mag rem;
        t_dq  dq;
        t_mag dvs;
    } t_div;

endpackage

// File: sv/lip_cross.sv
// Front end: coordinate differences, cross products and their magnitudes.
// Three register stages; uses lip_pkg.
module lip_cross (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  lip_pkg::t_coord     i_x1,
    input  lip_pkg::t_coord     i_y1,
    input  lip_pkg::t_coord     i_x2,
    input  lip_pkg::t_coord     i_y2,
    input  lip_pkg::t_coord     i_x3,
    input  lip_pkg::t_coord     i_y3,
    input  lip_pkg::t_coord     i_x4,
    input  lip_pkg::t_coord     i_y4,
    output lip_pkg::t_ctl       o_ctl,
    output lip_pkg::t_mag       o_num_mag,
    output lip_pkg::t_mag       o_den_mag
);

    logic            r_v1, r_v2;
    lip_pkg::t_diff  r_dx43, r_dy13, r_dy43, r_dx13, r_dx21, r_dy21;
    lip_pkg::t_prod  r_pn0, r_pn1, r_pd0, r_pd1;
    lip_pkg::t_ctl   r_ctl;
    lip_pkg::t_mag   r_num_mag, r_den_mag;

    lip_pkg::t_cross w_num, w_den, w_num_abs, w_den_abs;
    lip_pkg::t_ctl   n_ctl;

    always_comb begin
        w_num     = lip_pkg::t_cross'(r_pn0) - lip_pkg::t_cross'(r_pn1);
        w_den     = lip_pkg::t_cross'(r_pd0) - lip_pkg::t_cross'(r_pd1);
        w_num_abs = w_num[lip_pkg::CROSS_W-1] ? -w_num : w_num;
        w_den_abs = w_den[lip_pkg::CROSS_W-1] ? -w_den : w_den;
        n_ctl.valid = r_v2;
        n_ctl.neg   = w_num[lip_pkg::CROSS_W-1] ^ w_den[lip_pkg::CROSS_W-1];
        n_ctl.zero  = (w_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_ctl <= '0;
        end else if (i_en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx43 <= lip_pkg::t_diff'(i_x4) - lip_pkg::t_diff'(i_x3);
            r_dy13 <= lip_pkg::t_diff'(i_y1) - lip_pkg::t_diff'(i_y3);
            r_dy43 <= lip_pkg::t_diff'(i_y4) - lip_pkg::t_diff'(i_y3);
            r_dx13 <= lip_pkg::t_diff'(i_x1) - lip_pkg::t_diff'(i_x3);
            r_dx21 <= lip_pkg::t_diff'(i_x2) - lip_pkg::t_diff'(i_x1);
            r_dy21 <= lip_pkg::t_diff'(i_y2) - lip_pkg::t_diff'(i_y1);

            r_pn0 <= lip_pkg::t_prod'(r_dx43) * lip_pkg::t_prod'(r_dy13);
            r_pn1 <= lip_pkg::t_prod'(r_dy43) * lip_pkg::t_prod'(r_dx13);
            r_pd0 <= lip_pkg::t_prod'(r_dy43) * lip_pkg::t_prod'(r_dx21);
            r_pd1 <= lip_pkg::t_prod'(r_dx43) * lip_pkg::t_prod'(r_dy21);

            r_num_mag <= w_num_abs[lip_pkg::MAG_W-1:0];
            r_den_mag <= w_den_abs[lip_pkg::MAG_W-1:0];
        end
    end

    assign o_ctl     = r_ctl;
    assign o_num_mag = r_num_mag;
    assign o_den_mag = r_den_mag;

endmodule

// File: sv/lip_div_step.sv
// One registered step of the restoring divider: one quotient bit per stage.
// Uses lip_pkg.
module lip_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  lip_pkg::t_ctl  i_ctl,
    input  lip_pkg::t_div  i_div,
    output lip_pkg::t_ctl  o_ctl,
    output lip_pkg::t_div  o_div
);

    logic [lip_pkg::MAG_W:0] w_trial, w_diff;
    logic                    w_ge;
    lip_pkg::t_div           n_div;
    lip_pkg::t_ctl           r_ctl;
    lip_pkg::t_div           r_div;

    always_comb begin
        // Bring down the next dividend bit and try the subtraction.
        w_trial   = {i_div.rem, i_div.dq[lip_pkg::DVD_W-1]};
        w_diff    = w_trial - {1'b0, i_div.dvs};
        w_ge      = (w_trial >= {1'b0, i_div.dvs});
        n_div.rem = w_ge ? w_diff[lip_pkg::MAG_W-1:0] : w_trial[lip_pkg::MAG_W-1:0];
        n_div.dq  = {i_div.dq[lip_pkg::DVD_W-2:0], w_ge};
        n_div.dvs = i_div.dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_ctl = r_ctl;
    assign o_div = r_div;

endmodule

// File: sv/lip_div.sv
// Pipelined unsigned divider: (num << FRAC_BITS) / den, one step per stage.
// Uses lip_pkg and lip_div_step.
module lip_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  lip_pkg::t_ctl  i_ctl,
    input  lip_pkg::t_mag  i_num,
    input  lip_pkg::t_mag  i_den,
    output lip_pkg::t_ctl  o_ctl,
    output lip_pkg::t_dq   o_quo
);

    lip_pkg::t_ctl w_ctl [0:lip_pkg::DVD_W];
    lip_pkg::t_div w_div [0:lip_pkg::DVD_W];

    always_comb begin
        w_ctl[0]     = i_ctl;
        w_div[0].rem = '0;
        w_div[0].dq  = lip_pkg::t_dq'(i_num) << lip_pkg::FRAC_BITS;
        w_div[0].dvs = i_den;
    end

    for (genvar g = 0; g < lip_pkg::DVD_W; g++) begin : g_step
        lip_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_ctl   (w_ctl[g]),
            .i_div   (w_div[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    assign o_ctl = w_ctl[lip_pkg::DVD_W];
    assign o_quo = w_div[lip_pkg::DVD_W].dq;

endmodule

// File: sv/lip_sat.sv
// Output stage: clamps the quotient, applies the sign and handles parallel lines.
// Uses lip_pkg.
module lip_sat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  lip_pkg::t_ctl        i_ctl,
    input  lip_pkg::t_dq         i_quo,
    output logic                 o_valid,
    output logic signed [lip_pkg::OUT_BITS-1:0] o_t_value,
    output logic                 o_parallel,
    output logic                 o_saturated
);

    lip_pkg::t_wide w_q, w_lim_wide;
    lip_pkg::t_out  w_lim, w_mag, n_value;
    logic           w_sat, n_sat, n_par;
    logic           r_valid, r_par, r_sat;
    lip_pkg::t_out  r_value;

    always_comb begin
        w_q        = lip_pkg::t_wide'(i_quo);
        w_lim      = i_ctl.neg ? lip_pkg::NEG_LIMIT : lip_pkg::POS_LIMIT;
        w_lim_wide = lip_pkg::t_wide'(w_lim);
        w_sat      = (w_q > w_lim_wide);
        w_mag      = w_sat ? w_lim : w_q[lip_pkg::OUT_BITS-1:0];
        if (i_ctl.zero) begin
            n_value = '0;
            n_par   = 1'b1;
            n_sat   = 1'b0;
        end else begin
            n_value = i_ctl.neg ? -w_mag : w_mag;
            n_par   = 1'b0;
            n_sat   = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_par   <= n_par;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_t_value   = r_value;
    assign o_parallel  = r_par;
    assign o_saturated = r_sat;

endmodule

// File: sv/line_intersection_parameter.sv
// Line intersection parameter t = num / den in signed fixed point.
// Three front-end stages, one divider stage per quotient bit, one output stage.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset (i_rst_n low, synchronous) clears every valid bit; data registers are not reset.
module line_intersection_parameter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  lip_pkg::t_coord       i_line1_start_x,
    input  lip_pkg::t_coord       i_line1_start_y,
    input  lip_pkg::t_coord       i_line1_end_x,
    input  lip_pkg::t_coord       i_line1_end_y,
    input  lip_pkg::t_coord       i_line2_start_x,
    input  lip_pkg::t_coord       i_line2_start_y,
    input  lip_pkg::t_coord       i_line2_end_x,
    input  lip_pkg::t_coord       i_line2_end_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [lip_pkg::OUT_BITS-1:0] o_t_value,
    output logic                  o_parallel,
    output logic                  o_saturated
);

    logic          w_en;
    lip_pkg::t_ctl w_cross_ctl, w_div_ctl;
    lip_pkg::t_mag w_num_mag, w_den_mag;
    lip_pkg::t_dq  w_quo;

    // The pipeline advances unless a finished item is held at the output.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    lip_cross u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_x1      (i_line1_start_x),
        .i_y1      (i_line1_start_y),
        .i_x2      (i_line1_end_x),
        .i_y2      (i_line1_end_y),
        .i_x3      (i_line2_start_x),
        .i_y3      (i_line2_start_y),
        .i_x4      (i_line2_end_x),
        .i_y4      (i_line2_end_y),
        .o_ctl     (w_cross_ctl),
        .o_num_mag (w_num_mag),
        .o_den_mag (w_den_mag)
    );

    lip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_cross_ctl),
        .i_num   (w_num_mag),
        .i_den   (w_den_mag),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_quo)
    );

    lip_sat u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_div_ctl),
        .i_quo       (w_quo),
        .o_valid     (o_valid),
        .o_t_value   (o_t_value),
        .o_parallel  (o_parallel),
        .o_saturated (o_saturated)
    );

endmodule
